>>> hw/rtl/slcan_command_line_parser_unit_macros.svh
// Assertion macros used by the line parser top level.
`ifndef SLCAN_COMMAND_LINE_PARSER_UNIT_MACROS_SVH
`define SLCAN_COMMAND_LINE_PARSER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define SLCAN_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define SLCAN_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define SLCAN_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLCAN_ASSERT(name, prop, msg)
`define SLCAN_ASSERT_IMPLIES(name, ante, cons, msg)
`define SLCAN_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

>>> hw/rtl/slcan_pkg.sv
// Shared types, character codes, command codes and helpers of the line parser.
package slcan_pkg;

    // Character codes
    localparam logic [7:0] CHAR_CR   = 8'd13;
    localparam logic [7:0] CHAR_LF   = 8'd10;
    localparam logic [7:0] CHAR_NUL  = 8'd0;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_1    = 8'h31;
    localparam logic [7:0] CHAR_8    = 8'h38;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UF   = 8'h46;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LF_HEX = 8'h66;
    localparam logic [7:0] CHAR_V_UP = 8'h56;
    localparam logic [7:0] CHAR_V_LO = 8'h76;
    localparam logic [7:0] CHAR_N_UP = 8'h4E;
    localparam logic [7:0] CHAR_C_UP = 8'h43;
    localparam logic [7:0] CHAR_S_UP = 8'h53;
    localparam logic [7:0] CHAR_Z_UP = 8'h5A;
    localparam logic [7:0] CHAR_M_UP = 8'h4D;
    localparam logic [7:0] CHAR_M_LO = 8'h6D;
    localparam logic [7:0] CHAR_L_UP = 8'h4C;
    localparam logic [7:0] CHAR_O_UP = 8'h4F;
    localparam logic [7:0] CHAR_T_LO = 8'h74;
    localparam logic [7:0] CHAR_T_UP = 8'h54;
    localparam logic [7:0] CHAR_R_LO = 8'h72;
    localparam logic [7:0] CHAR_R_UP = 8'h52;

    // Command kinds
    localparam logic [3:0] CMD_VERSION  = 4'd0;
    localparam logic [3:0] CMD_SW_VER   = 4'd1;
    localparam logic [3:0] CMD_SERIAL   = 4'd2;
    localparam logic [3:0] CMD_CLOSE    = 4'd3;
    localparam logic [3:0] CMD_SPEED    = 4'd4;
    localparam logic [3:0] CMD_TSTAMP   = 4'd5;
    localparam logic [3:0] CMD_FILTER   = 4'd6;
    localparam logic [3:0] CMD_LISTEN   = 4'd7;
    localparam logic [3:0] CMD_OPEN     = 4'd8;
    localparam logic [3:0] CMD_FRAME    = 4'd9;
    localparam logic [3:0] CMD_REMOTE   = 4'd10;

    // Identifier lengths in nibbles
    localparam logic [7:0] STD_ID_NIBBLES = 8'd3;
    localparam logic [7:0] EXT_ID_NIBBLES = 8'd8;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Snapshot of one finished line, passed from front to back
    typedef struct packed {
        logic [7:0]  first_char;
        logic [7:0]  second_char;
        logic [7:0]  line_len;
        logic [31:0] id;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic        field_error;
    } slcan_rec_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic nonempty;
    } slcan_q_status_t;

    function automatic logic is_frame(input logic [7:0] c);
        return (c == CHAR_T_LO) || (c == CHAR_T_UP) || (c == CHAR_R_LO) || (c == CHAR_R_UP);
    endfunction

    function automatic logic is_ext(input logic [7:0] c);
        return (c == CHAR_T_UP) || (c == CHAR_R_UP);
    endfunction

    function automatic logic is_rtr(input logic [7:0] c);
        return (c == CHAR_R_LO) || (c == CHAR_R_UP);
    endfunction

    function automatic logic is_known(input logic [7:0] c);
        return (c == CHAR_V_UP) || (c == CHAR_V_LO) || (c == CHAR_N_UP) || (c == CHAR_C_UP) ||
               (c == CHAR_S_UP) || (c == CHAR_Z_UP) || (c == CHAR_M_UP) || (c == CHAR_M_LO) ||
               (c == CHAR_L_UP) || (c == CHAR_O_UP) || is_frame(c);
    endfunction

    // Return {bad, value}; value is zero for a non-hex character
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b10000;
        if ((c >= CHAR_0) && (c <= CHAR_9))
            r = {1'b0, 4'(c - CHAR_0)};
        else if ((c >= CHAR_UA) && (c <= CHAR_UF))
            r = {1'b0, 4'(c - CHAR_UA + 8'd10)};
        else if ((c >= CHAR_LA) && (c <= CHAR_LF_HEX))
            r = {1'b0, 4'(c - CHAR_LA + 8'd10)};
        return r;
    endfunction

endpackage

>>> hw/rtl/slcan_line_front.sv
// Front end: collects bytes into a line and hands finished lines to the queue.
module slcan_line_front #(
    parameter int MAX_LINE = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [7:0]            rx_byte,
    input  slcan_pkg::slcan_q_status_t q_stat,
    output logic                  rec_push,
    output slcan_pkg::slcan_rec_t rec
);
    import slcan_pkg::*;

    localparam logic [7:0] LINE_MAX = 8'(MAX_LINE);

    logic [7:0]  count_reg, count_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic [31:0] id_reg, id_next;
    logic [3:0]  dlc_reg, dlc_next;
    logic [63:0] data_reg, data_next;
    logic        err_reg, err_next;
    logic        ended_reg, ended_next;

    logic        accept;
    logic        is_eol;
    logic [7:0]  id_len;
    logic [7:0]  q_pos;
    logic [3:0]  slot;
    logic [4:0]  nib;

    assign accept = push && !q_stat.full;
    assign is_eol = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
    assign id_len = is_ext(first_reg) ? EXT_ID_NIBBLES : STD_ID_NIBBLES;
    assign q_pos  = count_reg - (id_len + 8'd2);
    assign slot   = {q_pos[3:1], ~q_pos[0]};
    assign nib    = hex_nibble(rx_byte);

    // Hand the finished line to the queue
    assign rec.first_char  = first_reg;
    assign rec.second_char = second_reg;
    assign rec.line_len    = count_reg;
    assign rec.id          = id_reg;
    assign rec.dlc         = dlc_reg;
    assign rec.data        = data_reg;
    assign rec.field_error = err_reg;

    // Absorb one byte or close the line
    always_comb
    begin
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        id_next     = id_reg;
        dlc_next    = dlc_reg;
        data_next   = data_reg;
        err_next    = err_reg;
        ended_next  = ended_reg;
        rec_push    = 1'b0;
        if (accept)
        begin
            if (!is_eol)
            begin
                if (!ended_reg && (count_reg < LINE_MAX))
                begin
                    if (rx_byte == CHAR_NUL)
                    begin
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 8'd1;
                        if (count_reg == 8'd0)
                        begin
                            first_next = rx_byte;
                        end
                        else
                        begin
                            if (count_reg == 8'd1)
                                second_next = rx_byte;
                            if (is_frame(first_reg))
                            begin
                                priority if (count_reg <= id_len)
                                begin
                                    id_next = {id_reg[27:0], nib[3:0]};
                                    if (nib[4])
                                        err_next = 1'b1;
                                end
                                else if (count_reg == id_len + 8'd1)
                                begin
                                    if ((rx_byte >= CHAR_0) && (rx_byte <= CHAR_8))
                                        dlc_next = 4'(rx_byte - CHAR_0);
                                    else
                                        err_next = 1'b1;
                                end
                                else
                                begin
                                    if (!is_rtr(first_reg) &&
                                        (q_pos < {3'b000, dlc_reg, 1'b0}))
                                    begin
                                        for (int k = 0; k < 16; k++)
                                        begin
                                            if (slot == 4'(k))
                                                data_next[4*k +: 4] = data_reg[4*k +: 4] | nib[3:0];
                                        end
                                        if (nib[4])
                                            err_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            else
            begin
                rec_push    = (count_reg != 8'd0) && is_known(first_reg);
                count_next  = 8'd0;
                first_next  = 8'd0;
                second_next = 8'd0;
                id_next     = 32'd0;
                dlc_next    = 4'd0;
                data_next   = 64'd0;
                err_next    = 1'b0;
                ended_next  = 1'b0;
            end
        end
    end

    // Hold line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 8'd0;
            first_reg  <= 8'd0;
            second_reg <= 8'd0;
            id_reg     <= 32'd0;
            dlc_reg    <= 4'd0;
            data_reg   <= 64'd0;
            err_reg    <= 1'b0;
            ended_reg  <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            id_reg     <= id_next;
            dlc_reg    <= dlc_next;
            data_reg   <= data_next;
            err_reg    <= err_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

>>> hw/rtl/slcan_cmd_fifo.sv
// Short queue of finished lines between front and back.
module slcan_cmd_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  slcan_pkg::slcan_rec_t wr_rec,
    input  logic                  rd_en,
    output slcan_pkg::slcan_rec_t rd_rec,
    output slcan_pkg::slcan_q_status_t q_stat
);
    import slcan_pkg::*;

    slcan_rec_t             queue_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    assign q_stat.full     = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_stat.nonempty = (cnt_reg != '0);
    assign rd_rec          = queue_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (wr_en)
            queue_reg[wr_ptr_reg] <= wr_rec;
    end

endmodule

>>> hw/rtl/slcan_cmd_back.sv
// Back end: decodes a queued line into a command and holds it for the consumer.
module slcan_cmd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slcan_pkg::slcan_rec_t head,
    input  slcan_pkg::slcan_q_status_t q_stat,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic [3:0]            cmd_kind,
    output logic [3:0]            cmd_arg,
    output logic                  parse_error,
    output logic                  ext_frame,
    output logic                  remote_frame,
    output logic [31:0]           frame_id,
    output logic [3:0]            frame_dlc,
    output logic [63:0]           frame_data
);
    import slcan_pkg::*;

    logic        valid_reg, valid_next;
    logic [3:0]  kind_reg, arg_reg, dlc_reg;
    logic        err_reg, ext_reg, rtr_reg;
    logic [31:0] id_reg;
    logic [63:0] data_reg;

    logic [3:0]  d_kind, d_arg, d_dlc;
    logic        d_err, d_ext, d_rtr;
    logic [31:0] d_id;
    logic [63:0] d_data;
    logic [7:0]  need_hdr, need_all;
    logic        load;

    assign load     = q_stat.nonempty && (!valid_reg || pop);
    assign q_pop    = load;
    assign need_hdr = (is_ext(head.first_char) ? EXT_ID_NIBBLES : STD_ID_NIBBLES) + 8'd2;
    assign need_all = need_hdr + {3'b000, head.dlc, 1'b0};

    // Decode the head beat
    always_comb
    begin
        d_kind = CMD_VERSION;
        d_arg  = 4'd0;
        d_err  = 1'b0;
        d_ext  = 1'b0;
        d_rtr  = 1'b0;
        d_id   = 32'd0;
        d_dlc  = 4'd0;
        d_data = 64'd0;
        unique case (head.first_char)
            CHAR_V_UP: d_kind = CMD_VERSION;
            CHAR_V_LO: d_kind = CMD_SW_VER;
            CHAR_N_UP: d_kind = CMD_SERIAL;
            CHAR_C_UP: d_kind = CMD_CLOSE;
            CHAR_S_UP:
            begin
                d_kind = CMD_SPEED;
                if ((head.line_len >= 8'd2) && (head.second_char >= CHAR_0) &&
                    (head.second_char <= CHAR_8))
                    d_arg = 4'(head.second_char - CHAR_0);
                else
                    d_err = 1'b1;
            end
            CHAR_Z_UP:
            begin
                d_kind = CMD_TSTAMP;
                if ((head.line_len >= 8'd2) &&
                    ((head.second_char == CHAR_0) || (head.second_char == CHAR_1)))
                    d_arg = 4'(head.second_char - CHAR_0);
                else
                    d_err = 1'b1;
            end
            CHAR_M_UP, CHAR_M_LO:
            begin
                d_kind = CMD_FILTER;
                d_err  = 1'b1;
            end
            CHAR_L_UP: d_kind = CMD_LISTEN;
            CHAR_O_UP: d_kind = CMD_OPEN;
            CHAR_T_LO, CHAR_T_UP, CHAR_R_LO, CHAR_R_UP:
            begin
                d_ext  = is_ext(head.first_char);
                d_rtr  = is_rtr(head.first_char);
                d_kind = d_rtr ? CMD_REMOTE : CMD_FRAME;
                d_err  = head.field_error || (head.line_len < need_hdr) ||
                         (!d_rtr && (head.line_len < need_all));
                if (!d_err)
                begin
                    d_id   = head.id;
                    d_dlc  = head.dlc;
                    d_data = d_rtr ? 64'd0 : head.data;
                end
            end
            default: d_kind = CMD_VERSION;
        endcase
    end

    // Hold the output beat until it is taken
    assign valid_next = load ? 1'b1 : (pop ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= d_kind;
            arg_reg  <= d_arg;
            err_reg  <= d_err;
            ext_reg  <= d_ext;
            rtr_reg  <= d_rtr;
            id_reg   <= d_id;
            dlc_reg  <= d_dlc;
            data_reg <= d_data;
        end
    end

    assign empty        = !valid_reg;
    assign cmd_kind     = kind_reg;
    assign cmd_arg      = arg_reg;
    assign parse_error  = err_reg;
    assign ext_frame    = ext_reg;
    assign remote_frame = rtr_reg;
    assign frame_id     = id_reg;
    assign frame_dlc    = dlc_reg;
    assign frame_data   = data_reg;

endmodule

>>> hw/rtl/slcan_command_line_parser_unit.sv
// Top level of the serial-line ASCII command parser.
//
//  channel   direction  handshake    beat
//  input     in         push / full  rx_byte
//  result    out        empty / pop  cmd_kind .. frame_data
//
// One byte is taken every cycle while full is low; the line collector does
// constant work per byte.
// A finished line reaches the result ports through the command queue and then
// the decode output register, which loads when it is empty or being popped.
// full rises only when the four-entry command queue is full.
// Reset is asynchronous and active low; it empties the line and the queue.
`include "slcan_command_line_parser_unit_macros.svh"

module slcan_command_line_parser_unit #(
    parameter int MAX_LINE = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  cmd_kind,
    output logic [3:0]  cmd_arg,
    output logic        parse_error,
    output logic        ext_frame,
    output logic        remote_frame,
    output logic [31:0] frame_id,
    output logic [3:0]  frame_dlc,
    output logic [63:0] frame_data
);
    import slcan_pkg::*;

    slcan_q_status_t q_stat;
    slcan_rec_t      wr_rec;
    slcan_rec_t      head;
    logic            rec_push;
    logic            q_pop;

    assign full = q_stat.full;

    slcan_line_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .rx_byte  (rx_byte),
        .q_stat   (q_stat),
        .rec_push (rec_push),
        .rec      (wr_rec)
    );

    slcan_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (rec_push),
        .wr_rec (wr_rec),
        .rd_en  (q_pop),
        .rd_rec (head),
        .q_stat (q_stat)
    );

    slcan_cmd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .cmd_kind     (cmd_kind),
        .cmd_arg      (cmd_arg),
        .parse_error  (parse_error),
        .ext_frame    (ext_frame),
        .remote_frame (remote_frame),
        .frame_id     (frame_id),
        .frame_dlc    (frame_dlc),
        .frame_data   (frame_data)
    );

    `SLCAN_ASSERT(a_no_push_when_full, !(rec_push && q_stat.full), "line pushed into full queue")
    `SLCAN_ASSERT_IMPLIES(a_err_zero_payload, !empty && parse_error, (cmd_arg == 4'd0) && (frame_id == 32'd0) && (frame_dlc == 4'd0) && (frame_data == 64'd0), "error result carries payload")
    `SLCAN_ASSERT_IMPLIES(a_remote_no_data, !empty && remote_frame, (frame_data == 64'd0) && (cmd_kind == CMD_REMOTE), "remote frame carries data")
    `SLCAN_ASSERT_IMPLIES(a_plain_cmd_no_frame, !empty && (cmd_kind != CMD_FRAME) && (cmd_kind != CMD_REMOTE), !ext_frame && !remote_frame && (frame_id == 32'd0), "plain command carries frame fields")

endmodule
